// ----- rtl/core/kvt_pkg.sv -----
// Package for the key/value table: request and response payload types,
// request kinds and controller states. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kvt_pkg;

  localparam int REQ_KEY_W = 32;
  localparam int VALUE_W   = 64;

  typedef enum logic [1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_PUT    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_PROBE  = 2'd3
  } kvt_req_e;

  typedef struct packed {
    kvt_req_e               req_type;
    logic [REQ_KEY_W-1:0]   lookup_key;
    logic [VALUE_W-1:0]     new_value;
  } kvt_req_t;

  typedef struct packed {
    logic                   found;
    logic [VALUE_W-1:0]     value_out;
    logic                   status;
  } kvt_rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } kvt_state_e;

endpackage

`default_nettype wire

// ----- rtl/core/kvt_mem.sv -----
// Slot memory of the key/value table: one write port, one read port with
// registered read data. No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module kvt_mem #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4,
  parameter int DATA_W = 97
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/kvt_scan.sv -----
// Scan controller of the key/value table: clearing pass, linear slot scan,
// write-back and result formation. Uses kvt_pkg; drives kvt_mem.
`timescale 1ns / 1ps
`default_nettype none

module kvt_scan #(
  parameter int TABLE_DEPTH = 16,
  parameter int KEY_BITS    = 32,
  localparam int AddrW = $clog2(TABLE_DEPTH),
  localparam int KeyW  = (KEY_BITS < kvt_pkg::REQ_KEY_W) ? KEY_BITS : kvt_pkg::REQ_KEY_W,
  localparam int DataW = 1 + KeyW + kvt_pkg::VALUE_W
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_stall,
  input  wire kvt_pkg::kvt_req_t req,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output kvt_pkg::kvt_rsp_t     res,
  output logic                  wr_en,
  output logic [AddrW-1:0]      wr_addr,
  output logic [DataW-1:0]      wr_data,
  output logic                  rd_en,
  output logic [AddrW-1:0]      rd_addr,
  input  wire logic [DataW-1:0] rd_data
);

  localparam logic [AddrW-1:0] LastIdx = AddrW'(TABLE_DEPTH - 1);

  kvt_pkg::kvt_state_e state, state_next;
  kvt_pkg::kvt_req_t   req_q;
  logic [AddrW-1:0]    idx, idx_next;
  logic                chk;
  logic [AddrW-1:0]    chk_idx;
  logic                hit;
  logic [AddrW-1:0]    hit_idx;
  logic [kvt_pkg::VALUE_W-1:0] hit_value;
  logic                free_ok;
  logic [AddrW-1:0]    free_idx;

  logic                entry_valid;
  logic [KeyW-1:0]     entry_key;
  logic [KeyW-1:0]     req_key;
  logic                accept;

  assign entry_valid = rd_data[DataW-1];
  assign entry_key   = rd_data[DataW-2 -: KeyW];
  assign req_key     = req_q.lookup_key[KeyW-1:0];
  assign accept      = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kvt_pkg::ST_CLEAR;
      idx   <= '0;
      chk   <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      chk   <= rd_en;
    end
  end

  // Match and free-slot tracking; first hit and lowest free slot win.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit     <= 1'b0;
      free_ok <= 1'b0;
    end else if (accept) begin
      hit     <= 1'b0;
      free_ok <= 1'b0;
    end else if (chk) begin
      if (entry_valid && entry_key == req_key && !hit) begin
        hit <= 1'b1;
      end
      if (!entry_valid && !free_ok) begin
        free_ok <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_idx <= rd_addr;
    if (accept) begin
      req_q <= req;
    end
    if (chk && entry_valid && entry_key == req_key && !hit) begin
      hit_idx   <= chk_idx;
      hit_value <= rd_data[kvt_pkg::VALUE_W-1:0];
    end
    if (chk && !entry_valid && !free_ok) begin
      free_idx <= chk_idx;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    req_stall  = 1'b1;
    res_valid  = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = idx;
    wr_en      = 1'b0;
    wr_addr    = idx;
    wr_data    = '0;
    case (state)
      kvt_pkg::ST_CLEAR: begin
        wr_en    = 1'b1;
        idx_next = idx + 1'b1;
        if (idx == LastIdx) begin
          idx_next   = '0;
          state_next = kvt_pkg::ST_IDLE;
        end
      end
      kvt_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          idx_next   = '0;
          state_next = kvt_pkg::ST_SCAN;
        end
      end
      kvt_pkg::ST_SCAN: begin
        rd_en    = 1'b1;
        idx_next = idx + 1'b1;
        if (idx == LastIdx) begin
          idx_next   = '0;
          state_next = kvt_pkg::ST_DRAIN;
        end
      end
      kvt_pkg::ST_DRAIN: begin
        state_next = kvt_pkg::ST_DONE;
      end
      kvt_pkg::ST_DONE: begin
        res_valid = 1'b1;
        case (req_q.req_type)
          kvt_pkg::REQ_PUT: begin
            wr_data = {1'b1, req_key, req_q.new_value};
            if (hit) begin
              wr_en   = res_ready;
              wr_addr = hit_idx;
            end else if (free_ok) begin
              wr_en   = res_ready;
              wr_addr = free_idx;
            end
          end
          kvt_pkg::REQ_REMOVE: begin
            wr_data = {1'b0, req_key, req_q.new_value};
            wr_en   = res_ready && hit;
            wr_addr = hit_idx;
          end
          default: begin
            wr_en = 1'b0;
          end
        endcase
        if (res_ready) begin
          state_next = kvt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = kvt_pkg::ST_CLEAR;
        idx_next   = '0;
      end
    endcase
  end

  always_comb begin
    res.found     = hit;
    res.value_out = (req_q.req_type == kvt_pkg::REQ_LOOKUP && hit) ? hit_value : '0;
    res.status    = (req_q.req_type == kvt_pkg::REQ_PUT) && !hit && !free_ok;
  end

  a_write_window: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == kvt_pkg::ST_CLEAR || (state == kvt_pkg::ST_DONE && res_ready)))
    else $error("slot write outside clearing pass or write-back");

  a_full_is_miss: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status) |-> (!res.found && req_q.req_type == kvt_pkg::REQ_PUT))
    else $error("full status on a hit or on a non-put request");

  a_value_needs_hit: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.value_out != '0) |-> res.found)
    else $error("nonzero value returned without a hit");

  a_no_stray_read: assert property (@(posedge clk) disable iff (rst)
    (state == kvt_pkg::ST_IDLE || state == kvt_pkg::ST_CLEAR) |-> !rd_en)
    else $error("slot read outside a scan");

endmodule

`default_nettype wire

// ----- rtl/core/key_value_table.sv -----
// Key/value table top level: scan controller, slot memory and response
// register. Uses kvt_pkg, kvt_scan and kvt_mem.
//
// Fixed-capacity table of unique key/value pairs searched linearly. Each
// request (lookup, put, remove, probe) yields exactly one response; found
// reports whether the key was present before the request. After reset the
// block runs a clearing pass over every slot with req_stall high, then
// takes one request at a time. A request reads every slot once through the
// single read port of the slot memory, one slot per cycle; from acceptance
// to the next acceptance it passes through the slot reads, a drain state
// for the last read data, a state that writes back and hands over the
// response (held there until the output register can take it), and an
// idle state. A put of a new key takes the lowest free slot; a put into a
// full table is dropped with status 1. Only the low min(KEY_BITS, 32) bits
// of lookup_key take part in matching. The response sits in an output
// register, so a stalled response does not block the next request until
// that one is ready to be handed over.
`timescale 1ns / 1ps
`default_nettype none

module key_value_table #(
  parameter int TABLE_DEPTH = 16,
  parameter int KEY_BITS    = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire kvt_pkg::kvt_req_t req,
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output kvt_pkg::kvt_rsp_t      rsp
);

  localparam int AddrW = $clog2(TABLE_DEPTH);
  localparam int KeyW  = (KEY_BITS < kvt_pkg::REQ_KEY_W) ? KEY_BITS : kvt_pkg::REQ_KEY_W;
  localparam int DataW = 1 + KeyW + kvt_pkg::VALUE_W;

  logic              res_valid;
  logic              res_ready;
  kvt_pkg::kvt_rsp_t res;

  logic              wr_en;
  logic [AddrW-1:0]  wr_addr;
  logic [DataW-1:0]  wr_data;
  logic              rd_en;
  logic [AddrW-1:0]  rd_addr;
  logic [DataW-1:0]  rd_data;

  kvt_scan #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  kvt_mem #(
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (AddrW),
    .DATA_W (DataW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Take a new response when the output register is empty or draining now.
  assign res_ready = !rsp_valid || !rsp_stall;

  // Hold the response while stalled; advance when the register frees up.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp <= res;
    end
  end

endmodule

`default_nettype wire
